>>> sv/itoa_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
package itoa_pkg;

    localparam int DEFAULT_MAX_FIELD_WIDTH = 64;
    // 22 octal digits cover 64 bits; decimal needs 20, hex 16.
    localparam int DIGIT_CELLS = 22;
    localparam int DIGIT_W = 4;
    localparam int VALUE_W = 64;
    localparam int ND_W = $clog2(DIGIT_CELLS + 1);
    localparam int CONV_W = $clog2(VALUE_W);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOWX  = 8'h78;
    localparam logic [7:0] CH_UPX   = 8'h58;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_HEX = 2'd2
    } radix_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_PLAN,
        S_EMIT
    } state_t;

    // Output segments in emission order.
    typedef enum logic [2:0] {
        SEG_NONE,
        SEG_LEAD,
        SEG_SIGN,
        SEG_PFX0,
        SEG_PFXX,
        SEG_ZERO,
        SEG_DIG,
        SEG_TRAIL
    } seg_t;

    typedef struct packed {
        logic clear;   // zero every digit
        logic conv;    // shift one magnitude bit in at the low end
        logic shift;   // move digits one place toward the top cell
        logic bit_in;  // magnitude bit for the low cell
    } chain_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UPA : CH_LOWA;
            if (d < 4'd10)
                digit_char = CH_ZERO + 8'(d);
            else
                digit_char = base + 8'(d) - 8'd10;
        end
    endfunction

endpackage

>>> sv/itoa_cell.sv
// One digit cell: doubles its digit plus carry-in modulo the radix, or shifts.
module itoa_cell (
    input  logic                            clk,
    input  itoa_pkg::chain_ctrl_t           ctrl,
    input  itoa_pkg::radix_t                radix,
    input  logic                            cin,
    input  logic [itoa_pkg::DIGIT_W-1:0]    din,
    output logic                            cout,
    output logic [itoa_pkg::DIGIT_W-1:0]    dout
);

    logic [itoa_pkg::DIGIT_W-1:0] digit_reg;
    logic [itoa_pkg::DIGIT_W-1:0] digit_next;
    logic [itoa_pkg::DIGIT_W-1:0] conv_digit;
    logic [itoa_pkg::DIGIT_W:0]   dbl;

    assign dbl  = {digit_reg, cin};
    assign dout = digit_reg;

    always_comb
    begin
        cout       = 1'b0;
        conv_digit = dbl[itoa_pkg::DIGIT_W-1:0];
        case (radix)
            itoa_pkg::RADIX_DEC:
            begin
                if (dbl >= 5'd10)
                begin
                    cout       = 1'b1;
                    conv_digit = 4'(dbl - 5'd10);
                end
                else
                begin
                    conv_digit = dbl[itoa_pkg::DIGIT_W-1:0];
                end
            end
            itoa_pkg::RADIX_OCT:
            begin
                cout       = dbl[3];
                conv_digit = {1'b0, dbl[2:0]};
            end
            default:
            begin
                cout       = dbl[4];
                conv_digit = dbl[3:0];
            end
        endcase
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
            digit_next = '0;
        else if (ctrl.conv)
            digit_next = conv_digit;
        else if (ctrl.shift)
            digit_next = din;
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

>>> sv/itoa_chain.sv
// Row of digit cells; cell 0 is least significant, the top cell feeds output.
module itoa_chain (
    input  logic                            clk,
    input  itoa_pkg::chain_ctrl_t           ctrl,
    input  itoa_pkg::radix_t                radix,
    output logic [itoa_pkg::DIGIT_W-1:0]    top_digit
);

    logic [itoa_pkg::DIGIT_CELLS:0]      carry;
    logic [itoa_pkg::DIGIT_W-1:0]        digit [itoa_pkg::DIGIT_CELLS+1];

    assign carry[0] = ctrl.bit_in;
    assign digit[0] = '0;
    assign top_digit = digit[itoa_pkg::DIGIT_CELLS];

    for (genvar i = 0; i < itoa_pkg::DIGIT_CELLS; i++)
    begin : g_cell
        itoa_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .radix (radix),
            .cin   (carry[i]),
            .din   (digit[i]),
            .cout  (carry[i+1]),
            .dout  (digit[i+1])
        );
    end

endmodule

>>> sv/integer_to_ascii_formatter.sv
// Top level: printf-style integer conversion, one character per output request.
//
// One request is taken at a time. The magnitude is shifted into a row of 22
// digit cells one bit per cycle, the row is then shifted up until the most
// significant digit reaches the top cell, the plan state sizes the fields, and
// the characters follow at one per cycle while the output is not stalled, with
// no character sent while the next layout segment is entered. The output
// register can be refilled in the cycle its character is taken.
module integer_to_ascii_formatter #(
    parameter int MAX_FIELD_WIDTH = itoa_pkg::DEFAULT_MAX_FIELD_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [63:0] value,
    input  logic               is_unsigned,
    input  logic [1:0]         radix_sel,
    input  logic               left_justify,
    input  logic               force_sign,
    input  logic               alt_form,
    input  logic               zero_pad,
    input  logic               uppercase,
    input  logic [6:0]         field_width,
    input  logic [5:0]         min_digits,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         char_out,
    output logic               last_char
);

    localparam int CNT_W = $clog2(MAX_FIELD_WIDTH + 8);

    itoa_pkg::state_t       state_reg, state_next;
    itoa_pkg::seg_t         seg_reg, seg_next, seg_after;
    itoa_pkg::chain_ctrl_t  ctrl;
    itoa_pkg::radix_t       radix_reg;

    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [CNT_W-1:0]                 rem_reg, rem_next;
    logic [CNT_W-1:0]                 pad_reg, pad_next;
    logic [CNT_W-1:0]                 lz_reg, lz_next;
    logic [CNT_W-1:0]                 after_len;
    logic [itoa_pkg::CONV_W-1:0]      conv_cnt_reg, conv_cnt_next;
    logic [itoa_pkg::ND_W-1:0]        nd_reg, nd_next;
    logic [63:0]                      mag_reg, mag_next;
    logic                             pfx_reg, pfx_next;
    logic                             has_sign_reg;
    logic [7:0]                       sign_reg;
    logic                             alt_reg, left_reg, zpad_reg, upper_reg;
    logic [6:0]                       width_reg;
    logic [5:0]                       mind_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [7:0]                       char_reg, char_next;
    logic                             last_reg, last_next;
    logic [itoa_pkg::DIGIT_W-1:0]     top_digit;

    logic                             accept;
    logic                             slot_free;
    logic                             out_load;
    logic                             neg;

    // sizing
    logic [CNT_W-1:0] wsat, prec1, prec2, prec3, nd_c, ndig, body, total;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != itoa_pkg::S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign last_char = last_reg;
    assign neg       = !is_unsigned && value[63];

    itoa_chain u_chain (
        .clk       (clk),
        .ctrl      (ctrl),
        .radix     (radix_reg),
        .top_digit (top_digit)
    );

    // Field sizing, used in the plan cycle.
    always_comb
    begin
        nd_c  = CNT_W'(nd_reg);
        wsat  = (width_reg > 7'(MAX_FIELD_WIDTH)) ? CNT_W'(MAX_FIELD_WIDTH)
                                                  : CNT_W'(width_reg);
        prec1 = (mind_reg == 6'd0) ? CNT_W'(1) : CNT_W'(mind_reg);
        // saturate before narrowing to the count width
        prec2 = (mind_reg > 6'(MAX_FIELD_WIDTH - 3)) ? CNT_W'(MAX_FIELD_WIDTH - 3) : prec1;
        // octal alternate form needs a leading zero digit
        prec3 = (radix_reg == itoa_pkg::RADIX_OCT && alt_reg && nd_reg != '0 && prec2 <= nd_c)
                ? nd_c + CNT_W'(1) : prec2;
        ndig  = (nd_c > prec3) ? nd_c : prec3;
        pfx_next = (radix_reg == itoa_pkg::RADIX_HEX) && alt_reg && (nd_reg != '0);
        body  = ndig + CNT_W'(has_sign_reg) + (pfx_next ? CNT_W'(2) : CNT_W'(0));
        total = (wsat > body) ? wsat : body;
        pad_next = total - body;
        lz_next  = ndig - nd_c;
    end

    // Segment following the current one and its length.
    always_comb
    begin
        case (seg_reg)
            itoa_pkg::SEG_NONE: seg_after = itoa_pkg::SEG_LEAD;
            itoa_pkg::SEG_LEAD: seg_after = itoa_pkg::SEG_SIGN;
            itoa_pkg::SEG_SIGN: seg_after = itoa_pkg::SEG_PFX0;
            itoa_pkg::SEG_PFX0: seg_after = itoa_pkg::SEG_PFXX;
            itoa_pkg::SEG_PFXX: seg_after = itoa_pkg::SEG_ZERO;
            itoa_pkg::SEG_ZERO: seg_after = itoa_pkg::SEG_DIG;
            default:            seg_after = itoa_pkg::SEG_TRAIL;
        endcase
        case (seg_after)
            itoa_pkg::SEG_LEAD:  after_len = (!left_reg && !zpad_reg) ? pad_reg : '0;
            itoa_pkg::SEG_SIGN:  after_len = CNT_W'(has_sign_reg);
            itoa_pkg::SEG_PFX0:  after_len = CNT_W'(pfx_reg);
            itoa_pkg::SEG_PFXX:  after_len = CNT_W'(pfx_reg);
            itoa_pkg::SEG_ZERO:  after_len = lz_reg + ((!left_reg && zpad_reg) ? pad_reg : '0);
            itoa_pkg::SEG_DIG:   after_len = CNT_W'(nd_reg);
            itoa_pkg::SEG_TRAIL: after_len = left_reg ? pad_reg : '0;
            default:             after_len = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        conv_cnt_next  = conv_cnt_reg;
        nd_next        = nd_reg;
        mag_next       = mag_reg;
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        out_load       = 1'b0;
        ctrl           = '0;

        case (state_reg)
            itoa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.clear    = 1'b1;
                    mag_next      = neg ? (64'd0 - $unsigned(value)) : $unsigned(value);
                    conv_cnt_next = '0;
                    nd_next       = itoa_pkg::ND_W'(itoa_pkg::DIGIT_CELLS);
                    state_next    = itoa_pkg::S_CONV;
                end
            end
            itoa_pkg::S_CONV:
            begin
                ctrl.conv     = 1'b1;
                ctrl.bit_in   = mag_reg[63];
                mag_next      = {mag_reg[62:0], 1'b0};
                conv_cnt_next = conv_cnt_reg + 1'b1;
                if (conv_cnt_reg == itoa_pkg::CONV_W'(itoa_pkg::VALUE_W - 1))
                    state_next = itoa_pkg::S_NORM;
            end
            itoa_pkg::S_NORM:
            begin
                // bring the most significant digit up to the top cell
                if (nd_reg == '0 || top_digit != '0)
                begin
                    state_next = itoa_pkg::S_PLAN;
                end
                else
                begin
                    ctrl.shift = 1'b1;
                    nd_next    = nd_reg - 1'b1;
                end
            end
            itoa_pkg::S_PLAN:
            begin
                rem_next   = total;
                seg_next   = itoa_pkg::SEG_NONE;
                cnt_next   = '0;
                state_next = itoa_pkg::S_EMIT;
            end
            itoa_pkg::S_EMIT:
            begin
                if (cnt_reg == '0)
                begin
                    seg_next = seg_after;
                    cnt_next = after_len;
                    if (seg_reg == itoa_pkg::SEG_TRAIL)
                        state_next = itoa_pkg::S_IDLE;
                end
                else if (slot_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    last_next      = (rem_reg == CNT_W'(1));
                    cnt_next       = cnt_reg - 1'b1;
                    rem_next       = rem_reg - 1'b1;
                    case (seg_reg)
                        itoa_pkg::SEG_SIGN: char_next = sign_reg;
                        itoa_pkg::SEG_PFX0: char_next = itoa_pkg::CH_ZERO;
                        itoa_pkg::SEG_PFXX:
                            char_next = upper_reg ? itoa_pkg::CH_UPX : itoa_pkg::CH_LOWX;
                        itoa_pkg::SEG_ZERO: char_next = itoa_pkg::CH_ZERO;
                        itoa_pkg::SEG_DIG:
                        begin
                            char_next  = itoa_pkg::digit_char(top_digit, upper_reg);
                            ctrl.shift = 1'b1;
                        end
                        default:            char_next = itoa_pkg::CH_SPACE;
                    endcase
                    if (rem_reg == CNT_W'(1))
                        state_next = itoa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = itoa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= itoa_pkg::S_IDLE;
            seg_reg       <= itoa_pkg::SEG_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        rem_reg      <= rem_next;
        conv_cnt_reg <= conv_cnt_next;
        nd_reg       <= nd_next;
        mag_reg      <= mag_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
        if (state_reg == itoa_pkg::S_PLAN)
        begin
            pad_reg <= pad_next;
            lz_reg  <= lz_next;
            pfx_reg <= pfx_next;
        end
        if (accept)
        begin
            case (radix_sel)
                itoa_pkg::RADIX_DEC: radix_reg <= itoa_pkg::RADIX_DEC;
                itoa_pkg::RADIX_OCT: radix_reg <= itoa_pkg::RADIX_OCT;
                default:             radix_reg <= itoa_pkg::RADIX_HEX;
            endcase
            has_sign_reg <= !is_unsigned && (value[63] || force_sign);
            sign_reg     <= neg ? itoa_pkg::CH_MINUS : itoa_pkg::CH_PLUS;
            alt_reg      <= alt_form;
            left_reg     <= left_justify;
            zpad_reg     <= zero_pad;
            upper_reg    <= uppercase;
            width_reg    <= field_width;
            mind_reg     <= min_digits;
        end
    end

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_next) |=> (state_reg == itoa_pkg::S_IDLE))
        else $error("last character did not end the request");

    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == itoa_pkg::S_CONV))
        else $error("accepted request did not start conversion");

    a_emit_has_chars: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itoa_pkg::S_EMIT) |-> (rem_reg != '0))
        else $error("emitting with no characters left");

    a_conv_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itoa_pkg::S_CONV &&
         conv_cnt_reg == itoa_pkg::CONV_W'(itoa_pkg::VALUE_W - 1))
        |=> (state_reg == itoa_pkg::S_NORM))
        else $error("conversion did not end after all magnitude bits");

endmodule

>>> test/integer_to_ascii_formatter_test.sv
// Testbench for the integer to ASCII formatter: directed and random requests, checked per character.

typedef struct {
    logic signed [63:0] value;
    logic               is_unsigned;
    logic [1:0]         radix_sel;
    logic               left_justify;
    logic               force_sign;
    logic               alt_form;
    logic               zero_pad;
    logic               uppercase;
    logic [6:0]         field_width;
    logic [5:0]         min_digits;
} fmt_spec_t;

typedef struct {
    logic [7:0] ch;
    logic       is_last;
} text_char_t;

class text_scoreboard;
    localparam int FIELD_LIMIT = itoa_pkg::DEFAULT_MAX_FIELD_WIDTH;

    text_char_t expected_chars[$];
    int         mismatches;
    int         chars_checked;
    int         conversions;

    function new();
        mismatches = 0;
        chars_checked = 0;
        conversions = 0;
    endfunction

    function int pending();
        return expected_chars.size();
    endfunction

    // Formats one accepted request and queues its characters.
    function void expect_conversion(fmt_spec_t s);
        bit [63:0]  mag;
        bit [63:0]  base;
        bit [63:0]  d;
        bit [7:0]   digits[$];
        bit [7:0]   text[$];
        bit [7:0]   sign_ch;
        bit [7:0]   alpha;
        bit         has_prefix;
        int         prec;
        int         wid;
        int         ndig;
        int         pad;
        text_char_t e;

        conversions++;
        mag = s.value;
        if (s.radix_sel == itoa_pkg::RADIX_DEC)
            base = 10;
        else if (s.radix_sel == itoa_pkg::RADIX_OCT)
            base = 8;
        else
            base = 16;

        sign_ch = 8'd0;
        if (!s.is_unsigned) begin
            if (s.value[63]) begin
                sign_ch = itoa_pkg::CH_MINUS;
                mag = ~s.value + 64'd1;
            end
            else if (s.force_sign)
                sign_ch = itoa_pkg::CH_PLUS;
        end

        alpha = s.uppercase ? itoa_pkg::CH_UPA : itoa_pkg::CH_LOWA;
        while (mag != 0) begin
            d = mag % base;
            mag = mag / base;
            if (d < 10)
                digits.push_front(itoa_pkg::CH_ZERO + 8'(d));
            else
                digits.push_front(alpha + 8'(d) - 8'd10);
        end

        prec = (s.min_digits == 0) ? 1 : int'(s.min_digits);
        if (prec > FIELD_LIMIT - 3)
            prec = FIELD_LIMIT - 3;
        wid = (s.field_width > FIELD_LIMIT) ? FIELD_LIMIT : int'(s.field_width);

        // octal alternate form needs one zero ahead of the top digit
        if (base == 8 && s.alt_form && digits.size() != 0 && prec <= digits.size())
            prec = digits.size() + 1;
        has_prefix = (base == 16) && s.alt_form && (digits.size() != 0);

        ndig = (digits.size() > prec) ? digits.size() : prec;
        pad = wid - (ndig + (sign_ch != 0 ? 1 : 0) + (has_prefix ? 2 : 0));
        if (pad < 0)
            pad = 0;

        if (!s.left_justify && !s.zero_pad)
            repeat (pad) text.push_back(itoa_pkg::CH_SPACE);
        if (sign_ch != 0)
            text.push_back(sign_ch);
        if (has_prefix) begin
            text.push_back(itoa_pkg::CH_ZERO);
            text.push_back(s.uppercase ? itoa_pkg::CH_UPX : itoa_pkg::CH_LOWX);
        end
        if (!s.left_justify && s.zero_pad)
            repeat (pad) text.push_back(itoa_pkg::CH_ZERO);
        repeat (ndig - digits.size()) text.push_back(itoa_pkg::CH_ZERO);
        foreach (digits[k])
            text.push_back(digits[k]);
        if (s.left_justify)
            repeat (pad) text.push_back(itoa_pkg::CH_SPACE);

        foreach (text[k]) begin
            e.ch = text[k];
            e.is_last = (k == text.size() - 1);
            expected_chars.push_back(e);
        end
    endfunction

    function void check_char(logic [7:0] ch, logic is_last);
        text_char_t e;

        if (expected_chars.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected char_out %h last_char %b, nothing pending",
                     $time, ch, is_last);
            return;
        end
        e = expected_chars.pop_front();
        chars_checked++;
        if (e.ch !== ch) begin
            mismatches++;
            $display("%0t: char_out expected %h actual %h", $time, e.ch, ch);
        end
        if (e.is_last !== is_last) begin
            mismatches++;
            $display("%0t: last_char expected %b actual %b", $time, e.is_last, is_last);
        end
    endfunction
endclass

module integer_to_ascii_formatter_test;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [63:0] value = '0;
    logic               is_unsigned = 1'b0;
    logic [1:0]         radix_sel = itoa_pkg::RADIX_DEC;
    logic               left_justify = 1'b0;
    logic               force_sign = 1'b0;
    logic               alt_form = 1'b0;
    logic               zero_pad = 1'b0;
    logic               uppercase = 1'b0;
    logic [6:0]         field_width = '0;
    logic [5:0]         min_digits = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [7:0]         char_out;
    logic               last_char;

    text_scoreboard board;
    bit             calm = 1'b0;
    bit             want_hold = 1'b0;
    bit             hold_taken = 1'b0;
    int             hold_left = 0;

    integer_to_ascii_formatter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .is_unsigned  (is_unsigned),
        .radix_sel    (radix_sel),
        .left_justify (left_justify),
        .force_sign   (force_sign),
        .alt_form     (alt_form),
        .zero_pad     (zero_pad),
        .uppercase    (uppercase),
        .field_width  (field_width),
        .min_digits   (min_digits),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .char_out     (char_out),
        .last_char    (last_char)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic fmt_spec_t make_spec(logic signed [63:0] v, logic uns, logic [1:0] rs,
                                            logic lj, logic fs, logic af, logic zp, logic uc,
                                            logic [6:0] fw, logic [5:0] md);
        fmt_spec_t s;

        s.value = v;
        s.is_unsigned = uns;
        s.radix_sel = rs;
        s.left_justify = lj;
        s.force_sign = fs;
        s.alt_form = af;
        s.zero_pad = zp;
        s.uppercase = uc;
        s.field_width = fw;
        s.min_digits = md;
        return s;
    endfunction

    task automatic send_request(fmt_spec_t s);
        value <= s.value;
        is_unsigned <= s.is_unsigned;
        radix_sel <= s.radix_sel;
        left_justify <= s.left_justify;
        force_sign <= s.force_sign;
        alt_form <= s.alt_form;
        zero_pad <= s.zero_pad;
        uppercase <= s.uppercase;
        field_width <= s.field_width;
        min_digits <= s.min_digits;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.expect_conversion(s);
    endtask

    // Occasional long gaps so idle time lands on every phase of a conversion.
    task automatic sender_gap();
        int gap;

        if (!calm && $urandom_range(99) < 26) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 180) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Output side: check accepted characters, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                board.check_char(char_out, last_char);
            if (want_hold && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 26);
        end
    end

    initial
    begin
        fmt_spec_t          directed[$];
        logic signed [63:0] v;
        logic [6:0]         fw;
        logic [5:0]         md;

        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // value, uns, radix, left, plus, alt, zpad, upper, width, digits
        directed.push_back(make_spec(64'sd0, 0, itoa_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_spec({1'b0, {63{1'b1}}}, 0, itoa_pkg::RADIX_DEC,
                                     0, 1, 0, 0, 0, 0, 1));
        directed.push_back(make_spec({1'b1, 63'd0}, 0, itoa_pkg::RADIX_DEC,
                                     0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_spec(-64'sd1, 1, itoa_pkg::RADIX_DEC, 0, 1, 0, 0, 0, 0, 0));
        directed.push_back(make_spec({1'b1, 63'd0}, 0, itoa_pkg::RADIX_HEX,
                                     0, 0, 1, 0, 1, 0, 0));
        directed.push_back(make_spec(-64'sd1, 1, itoa_pkg::RADIX_OCT, 0, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_spec(64'sd0, 0, itoa_pkg::RADIX_OCT, 0, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_spec(64'sd0, 0, itoa_pkg::RADIX_HEX, 0, 0, 1, 0, 1, 6, 0));
        directed.push_back(make_spec(64'sd48879, 1, 2'd3, 0, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_spec(64'sd42, 0, itoa_pkg::RADIX_DEC, 0, 1, 0, 1, 0, 10, 0));
        directed.push_back(make_spec(-64'sd42, 0, itoa_pkg::RADIX_DEC, 1, 0, 0, 1, 0, 12, 0));
        directed.push_back(make_spec(64'sd12345, 0, itoa_pkg::RADIX_DEC,
                                     0, 0, 0, 0, 0, 7'd127, 0));
        directed.push_back(make_spec(64'sd255, 0, itoa_pkg::RADIX_HEX,
                                     0, 1, 1, 0, 1, 7'd127, 6'd63));
        directed.push_back(make_spec(-64'sd511, 0, itoa_pkg::RADIX_OCT,
                                     0, 0, 1, 0, 0, 0, 6'd60));
        directed.push_back(make_spec(-64'sd7, 0, itoa_pkg::RADIX_DEC, 1, 0, 0, 0, 0, 64, 3));
        directed.push_back(make_spec(-64'sd3054, 0, itoa_pkg::RADIX_HEX,
                                     0, 0, 1, 1, 0, 20, 0));
        directed.push_back(make_spec(64'sd99, 1, itoa_pkg::RADIX_DEC, 0, 1, 0, 0, 0, 5, 0));
        directed.push_back(make_spec(64'sd7, 0, itoa_pkg::RADIX_OCT, 0, 0, 1, 0, 0, 0, 5));
        directed.push_back(make_spec(64'sd83, 0, itoa_pkg::RADIX_OCT, 0, 0, 1, 1, 0, 8, 1));
        directed.push_back(make_spec(64'sd3054, 0, itoa_pkg::RADIX_HEX, 0, 0, 0, 0, 1, 0, 0));
        directed.push_back(make_spec(-64'sd1, 0, itoa_pkg::RADIX_DEC, 0, 0, 0, 0, 0, 1, 0));
        directed.push_back(make_spec(64'shFEDCBA9876543210, 1, itoa_pkg::RADIX_HEX,
                                     0, 0, 1, 0, 0, 0, 0));
        directed.push_back(make_spec(64'sd5, 0, itoa_pkg::RADIX_DEC, 0, 1, 0, 1, 0, 64, 0));

        foreach (directed[i]) begin
            send_request(directed[i]);
            sender_gap();
        end

        for (int i = 0; i < 280; i++) begin
            calm = (i >= 100 && i < 140);
            // receiver holds off while requests keep coming
            if (i == 60)
                want_hold = 1'b1;
            // let the block drain completely before continuing
            if (i == 180) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (board.pending() != 0)
                    @(posedge clk);
            end

            case ($urandom_range(4))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(0, 999));
                2: v = 64'd0 - 64'($urandom_range(1, 99999));
                3: v = {$urandom, $urandom} >> $urandom_range(63);
                default:
                    case ($urandom_range(3))
                        0: v = '0;
                        1: v = '1;
                        2: v = {1'b0, {63{1'b1}}};
                        default: v = {1'b1, 63'd0};
                    endcase
            endcase
            fw = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
            md = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(25));

            send_request(make_spec(v, 1'($urandom_range(1)), 2'($urandom_range(3)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)),
                                   1'($urandom_range(1)), 1'($urandom_range(1)),
                                   1'($urandom_range(1)), fw, md));
            sender_gap();
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        $display("Ran %0d conversions, %0d characters checked: every radix incl. selector 3,",
                 board.conversions, board.chars_checked);
        $display("sign, prefix, padding and case flags, saturated widths, long output hold.");
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d characters still pending", board.pending());
        $display("== FAIL ==");
        $finish;
    end

endmodule
